@@ src/eap_pkg.sv @@
// ----------------------------------------------------------------------------
// eap_pkg
// Shared widths, constants, stage payload type and the energy helper for the
// energy accumulator average power pipeline.
// ----------------------------------------------------------------------------
package eap_pkg;

  // Field widths
  localparam int unsigned AccW  = 16;
  localparam int unsigned RollW = 8;
  localparam int unsigned SmpW  = 24;
  localparam int unsigned AvgW  = 25;

  // Magnitude width of energy, sample and quotient values inside the divider
  localparam int unsigned DivW = 24;

  // Weight of one accumulator rollover
  localparam logic [DivW-1:0] RollWeight = 24'd32767;

  // Quotient bits resolved per divider stage, and the resulting stage count
  localparam int unsigned DivSteps     = 4;
  localparam int unsigned NumDivStages = DivW / DivSteps;

  // Payload carried between the divider stages
  typedef struct packed {
    logic [DivW-1:0] rem;  // partial remainder
    logic [DivW-1:0] quo;  // dividend bits still to shift in, quotient bits shifted out
    logic [DivW-1:0] dvs;  // divisor magnitude
    logic            neg;  // result is negative
    logic            err;  // sample counts equal
  } eap_div_t;

  // Energy of one reading: rollover * 32767 + accumulator
  function automatic logic [DivW-1:0] eap_energy(logic [AccW-1:0]  acc,
                                                 logic [RollW-1:0] roll);
    logic [DivW-1:0] scaled;
    scaled = {{(DivW-RollW){1'b0}}, roll} * RollWeight;
    return scaled + {{(DivW-AccW){1'b0}}, acc};
  endfunction

endpackage

@@ src/eap_prep.sv @@
// ----------------------------------------------------------------------------
// eap_prep
// Entry stage: forms both energies, the signed energy and sample-count
// differences, and loads their magnitudes and the result sign into the divider.
// ----------------------------------------------------------------------------
module eap_prep
  import eap_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [AccW-1:0]  prev_accumulator_i,
  input  logic [RollW-1:0] prev_rollover_i,
  input  logic [SmpW-1:0]  prev_samples_i,
  input  logic [AccW-1:0]  cur_accumulator_i,
  input  logic [RollW-1:0] cur_rollover_i,
  input  logic [SmpW-1:0]  cur_samples_i,
  output logic             valid_o,
  output eap_div_t         data_o
);

  logic [DivW:0] de;
  logic [DivW:0] ds;
  logic [DivW:0] de_abs;
  logic [DivW:0] ds_abs;
  eap_div_t      data_d;
  eap_div_t      data_q;
  logic          valid_q;

  // Take signed differences, later minus earlier, and split sign from magnitude
  always_comb begin
    de = {1'b0, eap_energy(cur_accumulator_i, cur_rollover_i)}
       - {1'b0, eap_energy(prev_accumulator_i, prev_rollover_i)};
    ds = {1'b0, cur_samples_i} - {1'b0, prev_samples_i};
    de_abs = de[DivW] ? (~de + 1'b1) : de;
    ds_abs = ds[DivW] ? (~ds + 1'b1) : ds;
    data_d.rem = '0;
    data_d.quo = de_abs[DivW-1:0];
    data_d.dvs = ds_abs[DivW-1:0];
    data_d.neg = de[DivW] ^ ds[DivW];
    data_d.err = (ds == '0);
  end

  // Advance the valid bit every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload with its item
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/eap_div_stage.sv @@
// ----------------------------------------------------------------------------
// eap_div_stage
// One stage of the restoring divider: resolves DivSteps quotient bits of the
// magnitude division and registers the partial remainder and quotient.
// ----------------------------------------------------------------------------
module eap_div_stage
  import eap_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  eap_div_t data_i,
  output logic     valid_o,
  output eap_div_t data_o
);

  eap_div_t      data_d;
  eap_div_t      data_q;
  logic          valid_q;
  logic [DivW:0] trial;

  // Shift in one dividend bit per step, subtract the divisor where it fits
  always_comb begin
    data_d = data_i;
    trial  = '0;
    for (int i = 0; i < DivSteps; i++) begin
      trial      = {data_d.rem, data_d.quo[DivW-1]};
      data_d.quo = {data_d.quo[DivW-2:0], 1'b0};
      if (trial >= {1'b0, data_d.dvs}) begin
        trial         = trial - {1'b0, data_d.dvs};
        data_d.quo[0] = 1'b1;
      end
      data_d.rem = trial[DivW-1:0];
    end
  end

  // Advance the valid bit every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload with its item
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/eap_fix.sv @@
// ----------------------------------------------------------------------------
// eap_fix
// Exit stage: applies the sign to the quotient magnitude, forces zero on a
// divide error and registers the result with its strobe.
// ----------------------------------------------------------------------------
module eap_fix
  import eap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  eap_div_t               data_i,
  output logic                   done_o,
  output logic signed [AvgW-1:0] average_power_o,
  output logic                   divide_error_o
);

  logic [AvgW-1:0] mag;
  logic [AvgW-1:0] avg_d;
  logic [AvgW-1:0] avg_q;
  logic            err_q;
  logic            done_q;

  // Restore the sign; truncation toward zero follows from dividing magnitudes
  always_comb begin
    mag = {1'b0, data_i.quo};
    if (data_i.err) begin
      avg_d = '0;
    end else if (data_i.neg) begin
      avg_d = ~mag + 1'b1;
    end else begin
      avg_d = mag;
    end
  end

  // Raise the strobe for exactly one cycle per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // Hold the result fields
  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
    err_q <= data_i.err;
  end

  assign done_o          = done_q;
  assign average_power_o = $signed(avg_q);
  assign divide_error_o  = err_q;

endmodule

@@ src/energy_accumulator_average_power.sv @@
// ----------------------------------------------------------------------------
// energy_accumulator_average_power
// Average power between two energy-meter readings: energy difference over
// sample-count difference, truncated toward zero, with a divide error flag
// when the sample counts are equal.
//
//   channel   handshake          fields
//   -------   ----------------   ---------------------------------------------
//   command   start_i / busy_o   prev_/cur_ accumulator, rollover, samples
//   result    done_o (strobe)    average_power_o, divide_error_o
//
// One transfer is taken in every cycle; busy_o is never raised.
// Each result passes through one entry stage, six divider stages of four
// quotient bits each, and one exit stage.
// The divider stages set the depth; no item waits on another.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
module energy_accumulator_average_power
  import eap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [AccW-1:0]        prev_accumulator_i,
  input  logic [RollW-1:0]       prev_rollover_i,
  input  logic [SmpW-1:0]        prev_samples_i,
  input  logic [AccW-1:0]        cur_accumulator_i,
  input  logic [RollW-1:0]       cur_rollover_i,
  input  logic [SmpW-1:0]        cur_samples_i,
  output logic                   done_o,
  output logic signed [AvgW-1:0] average_power_o,
  output logic                   divide_error_o
);

  localparam int unsigned Latency = NumDivStages + 2;

  logic     stg_valid [NumDivStages+1];
  eap_div_t stg_data  [NumDivStages+1];

  // Accept a command in every cycle
  assign busy_o = 1'b0;

  // Load the divider
  eap_prep u_prep (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (start_i),
    .prev_accumulator_i (prev_accumulator_i),
    .prev_rollover_i    (prev_rollover_i),
    .prev_samples_i     (prev_samples_i),
    .cur_accumulator_i  (cur_accumulator_i),
    .cur_rollover_i     (cur_rollover_i),
    .cur_samples_i      (cur_samples_i),
    .valid_o            (stg_valid[0]),
    .data_o             (stg_data[0])
  );

  // Chain the divider stages
  for (genvar g = 0; g < NumDivStages; g++) begin : g_div
    eap_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // Sign and register the result
  eap_fix u_fix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (stg_valid[NumDivStages]),
    .data_i          (stg_data[NumDivStages]),
    .done_o          (done_o),
    .average_power_o (average_power_o),
    .divide_error_o  (divide_error_o)
  );

  // Every accepted command yields a result after the fixed latency
  a_cmd_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("command transfer without result");

  // No result without a command the fixed latency earlier
  a_done_from_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without command transfer");

  // A divide error gives a zero average
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_error_o) |-> (average_power_o == '0))
    else $error("divide error with non-zero average");

  // The divider remainder stays below the divisor
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[NumDivStages] && !stg_data[NumDivStages].err)
      |-> (stg_data[NumDivStages].rem < stg_data[NumDivStages].dvs))
    else $error("divider remainder out of range");

endmodule

@@ verif/average_power_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// average_power_checker
// Watches the command and result channels of the average power block,
// predicts each result from the two readings of every accepted command and
// compares it field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module average_power_checker
  import eap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [AccW-1:0]        prev_accumulator_i,
  input  logic [RollW-1:0]       prev_rollover_i,
  input  logic [SmpW-1:0]        prev_samples_i,
  input  logic [AccW-1:0]        cur_accumulator_i,
  input  logic [RollW-1:0]       cur_rollover_i,
  input  logic [SmpW-1:0]        cur_samples_i,
  input  logic                   done_i,
  input  logic signed [AvgW-1:0] average_power_i,
  input  logic                   divide_error_i,
  output int                     pending_o,
  output int                     errors_o
);

  typedef struct packed {
    logic [AvgW-1:0] avg;
    logic            err;
  } power_result_t;

  power_result_t expected_powers[$];

  // Energy of each reading, then the truncating quotient of the differences
  function automatic power_result_t average_power_of(
    logic [AccW-1:0] pa, logic [RollW-1:0] pr, logic [SmpW-1:0] ps,
    logic [AccW-1:0] ca, logic [RollW-1:0] cr, logic [SmpW-1:0] cs);
    longint        e_prev;
    longint        e_cur;
    longint        d_smp;
    longint        quot;
    power_result_t res;
    e_prev = longint'(pr) * longint'(RollWeight) + longint'(pa);
    e_cur  = longint'(cr) * longint'(RollWeight) + longint'(ca);
    d_smp  = longint'(cs) - longint'(ps);
    quot   = 0;
    res.err = 1'b0;
    if (d_smp == 0) begin
      res.err = 1'b1;
    end else begin
      quot = (e_cur - e_prev) / d_smp;
    end
    res.avg = quot[AvgW-1:0];
    return res;
  endfunction

  // Retire results against the oldest prediction, then record new commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    power_result_t want;
    int            delta;
    if (!rst_ni) begin
      expected_powers.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      delta = 0;
      if (done_i) begin
        if (expected_powers.size() == 0) begin
          errors_o <= errors_o + 1;
          $display("%0t: result with nothing outstanding: avg %0d err %0b",
                   $time, average_power_i, divide_error_i);
        end else begin
          want  = expected_powers.pop_front();
          delta = delta - 1;
          if (want.avg !== average_power_i || want.err !== divide_error_i) begin
            errors_o <= errors_o + 1;
            $display("%0t: mismatch: expected avg %0d err %0b, got avg %0d err %0b",
                     $time, $signed(want.avg), want.err,
                     average_power_i, divide_error_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_powers.push_back(average_power_of(
          prev_accumulator_i, prev_rollover_i, prev_samples_i,
          cur_accumulator_i, cur_rollover_i, cur_samples_i));
        delta = delta + 1;
      end
      pending_o <= pending_o + delta;
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives reading pairs into the average power block: a directed set of edge
// readings, then random pairs, first back to back, then with random idle gaps. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import eap_pkg::*;

  localparam int NumRandom = 1600;
  localparam int NoIdleRun = 200;
  localparam int DrainAt   = 800;
  localparam int TailWait  = 24;

  // Largest energy of a reading: 255 * 32767 + 65535
  localparam logic [AccW-1:0]  AccMax  = '1;
  localparam logic [RollW-1:0] RollMax = '1;
  localparam logic [SmpW-1:0]  SmpMax  = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [AccW-1:0]        prev_accumulator_i = '0;
  logic [RollW-1:0]       prev_rollover_i = '0;
  logic [SmpW-1:0]        prev_samples_i = '0;
  logic [AccW-1:0]        cur_accumulator_i = '0;
  logic [RollW-1:0]       cur_rollover_i = '0;
  logic [SmpW-1:0]        cur_samples_i = '0;
  logic                   done_o;
  logic signed [AvgW-1:0] average_power_o;
  logic                   divide_error_o;

  int pending;
  int errors;
  bit no_idle;

  energy_accumulator_average_power dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .prev_accumulator_i (prev_accumulator_i),
    .prev_rollover_i    (prev_rollover_i),
    .prev_samples_i     (prev_samples_i),
    .cur_accumulator_i  (cur_accumulator_i),
    .cur_rollover_i     (cur_rollover_i),
    .cur_samples_i      (cur_samples_i),
    .done_o             (done_o),
    .average_power_o    (average_power_o),
    .divide_error_o     (divide_error_o)
  );

  average_power_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .prev_accumulator_i (prev_accumulator_i),
    .prev_rollover_i    (prev_rollover_i),
    .prev_samples_i     (prev_samples_i),
    .cur_accumulator_i  (cur_accumulator_i),
    .cur_rollover_i     (cur_rollover_i),
    .cur_samples_i      (cur_samples_i),
    .done_i             (done_o),
    .average_power_i    (average_power_o),
    .divide_error_i     (divide_error_o),
    .pending_o          (pending),
    .errors_o           (errors)
  );

  // Clock, 12 ns period
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Give up well past the slowest correct run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one reading pair, hold it until the transfer, then idle a while
  task automatic send_pair(
    input logic [AccW-1:0] pa, input logic [RollW-1:0] pr, input logic [SmpW-1:0] ps,
    input logic [AccW-1:0] ca, input logic [RollW-1:0] cr, input logic [SmpW-1:0] cs);
    bit taken;
    int gap;
    prev_accumulator_i <= pa;
    prev_rollover_i    <= pr;
    prev_samples_i     <= ps;
    cur_accumulator_i  <= ca;
    cur_rollover_i     <= cr;
    cur_samples_i      <= cs;
    start_i            <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // One random pair, shaped after how meters are really read most of the time
  task automatic send_random();
    logic [AccW-1:0]  pa, ca;
    logic [RollW-1:0] pr, cr;
    logic [SmpW-1:0]  ps, cs;
    int               kind;
    int               off;
    pa   = AccW'($urandom);
    pr   = RollW'($urandom);
    ps   = SmpW'($urandom);
    ca   = AccW'($urandom);
    cr   = RollW'($urandom);
    cs   = SmpW'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // fully independent readings
    end else if (kind < 65) begin
      // later reading a little ahead of the earlier one, wrapping freely
      ca = pa + AccW'($urandom_range(0, 2000));
      cr = pr + RollW'($urandom_range(0, 1));
      cs = ps + SmpW'($urandom_range(1, 5000));
    end else if (kind < 75) begin
      // equal sample counts
      cs = ps;
    end else if (kind < 95) begin
      // few samples apart, large quotients of either sign
      off = $urandom_range(1, 16);
      if ($urandom_range(0, 1)) off = -off;
      cs = ps + off[SmpW-1:0];
    end else begin
      // extremes of energy
      pa = $urandom_range(0, 1) ? AccMax : '0;
      pr = $urandom_range(0, 1) ? RollMax : '0;
      ca = $urandom_range(0, 1) ? AccMax : '0;
      cr = $urandom_range(0, 1) ? RollMax : '0;
    end
    send_pair(pa, pr, ps, ca, cr, cs);
  endtask

  initial begin
    no_idle = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero and full readings, sign and truncation of the quotient
    send_pair('0, '0, '0, '0, '0, '0);
    send_pair(AccMax, RollMax, SmpMax, AccMax, RollMax, SmpMax);
    send_pair(AccMax, RollMax, 24'd0, '0, '0, 24'd1);
    send_pair('0, '0, 24'd0, AccMax, RollMax, 24'd1);
    send_pair('0, '0, 24'd1, AccMax, RollMax, 24'd0);
    send_pair(AccMax, RollMax, 24'd1, '0, '0, 24'd0);
    send_pair('0, '0, 24'd0, AccMax, RollMax, SmpMax);
    send_pair('0, '0, SmpMax, AccMax, RollMax, 24'd0);
    send_pair(16'd7, '0, 24'd0, 16'd0, '0, 24'd2);
    send_pair(16'd0, '0, 24'd2, 16'd7, '0, 24'd0);
    send_pair(16'd0, '0, 24'd0, 16'd7, '0, 24'd2);
    send_pair(16'd100, 8'd3, 24'd500, 16'd100, 8'd4, 24'd501);
    send_pair(16'd100, RollMax, 24'd500, 16'd100, 8'd0, 24'd501);
    send_pair(16'd10, 8'd1, SmpMax, 16'd20, 8'd1, 24'd0);
    send_pair(16'd1234, 8'd9, 24'd123456, 16'd4321, 8'd10, 24'd123456);
    send_pair(16'hAAAA, 8'hAA, 24'hAAAAAA, 16'h5555, 8'h55, 24'h555555);
    send_pair(16'h5555, 8'h55, 24'h555555, 16'hAAAA, 8'hAA, 24'hAAAAAA);
    send_pair(16'd0, '0, 24'd40, 16'd100, '0, 24'd50);
    send_pair(16'd65000, 8'd200, 24'd9000000, 16'd12, 8'd201, 24'd9000321);
    drain();

    // Random: a first stretch back to back, then idle gaps
    for (int i = 0; i < NumRandom; i++) begin
      no_idle = (i < NoIdleRun);
      send_random();
      if (i == DrainAt) drain();
    end

    // Wait for the last results, then allow for stray ones
    drain();
    repeat (TailWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
